// ===== design/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera reply parser package
// Character codes, parse mode codes and the request types that the camera
// reply parser and its stream interfaces share.
// ----------------------------------------------------------------------------
package crp_pkg;

    // Characters that steer the parser.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;

    // Parse mode codes. The fourth code never arises and behaves as idle.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_TRACK = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;

    // Number of stored color parameters and thresholds.
    localparam int NUM_COLOR = 6;

    // One received character.
    typedef struct packed {
        logic [7:0] rx_byte;
    } crp_request_t;

    // One parser result.
    typedef struct packed {
        logic [7:0] echo_byte;
        logic [7:0] centroid_x;
        logic       centroid_done;
        logic       prompt_seen;
        logic [7:0] red_low;
        logic [7:0] red_high;
        logic [7:0] green_low;
        logic [7:0] green_high;
        logic [7:0] blue_low;
        logic [7:0] blue_high;
        logic       thresholds_done;
    } crp_result_t;

    // Decimal shift-and-add with 8-bit wrap: acc * 10 + (b - '0').
    function automatic logic [7:0] dec_shift_add(input logic [7:0] acc, input logic [7:0] b);
        dec_shift_add = {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + b - DIGIT_0;
    endfunction

endpackage

// ===== design/crp_stream_if.sv =====
// ----------------------------------------------------------------------------
// Camera reply parser stream interface
// Valid/ready channel carrying one request of a given payload type.
// ----------------------------------------------------------------------------
interface crp_stream_if #(parameter type payload_t = logic [7:0]);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/camera_reply_parser.sv =====
// ----------------------------------------------------------------------------
// Camera reply parser
// Byte-serial parser for camera replies: echo, track centroid and identify
// color thresholds.
// ----------------------------------------------------------------------------
// The parser takes one received character per clock cycle while the output
// is not stalled, and returns exactly one result per character: the
// character is held in an input register, and when it moves on, the parser
// state and the result register are updated together. The state update is
// combinational (a decimal shift-and-add and three 8-bit subtract and add
// pairs). A result waiting on a stalled output lets one more character into
// the input register, which then holds it until the result is taken. Each
// result echoes the character and carries the current centroid, the six
// thresholds and pulses for centroid done, prompt seen and thresholds done.
module camera_reply_parser (
    input  logic clk,
    input  logic rst_n,
    crp_stream_if.sink   in_ch,
    crp_stream_if.source out_ch
);

    import crp_pkg::*;

    // Input stage.
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;

    // Result stage.
    logic        out_valid_reg;
    crp_result_t out_reg;
    crp_result_t out_next;

    // Parser state.
    logic [1:0]  mode_reg,     mode_next;
    logic        skip_reg,     skip_next;
    logic        in_num_reg,   in_num_next;
    logic [7:0]  field_reg,    field_next;
    logic [7:0]  accum_reg,    accum_next;
    logic [7:0]  centroid_reg, centroid_next;
    logic [7:0]  params_reg [NUM_COLOR];
    logic [7:0]  params_next [NUM_COLOR];
    logic [7:0]  thr_reg [NUM_COLOR];
    logic [7:0]  thr_next [NUM_COLOR];

    logic        out_free;
    logic        s1_move;

    // Handshake: the input register refills when it is empty or its content moves on.
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_move     = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || s1_move;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    // Parser state update for the character in the input register.
    always_comb
    begin
        logic [7:0] b;
        logic       cdone;
        logic       tdone;
        logic [7:0] acc_new;

        b             = s1_byte_reg;
        cdone         = 1'b0;
        tdone         = 1'b0;
        mode_next     = mode_reg;
        skip_next     = skip_reg;
        in_num_next   = in_num_reg;
        field_next    = field_reg;
        accum_next    = accum_reg;
        centroid_next = centroid_reg;
        params_next   = params_reg;
        thr_next      = thr_reg;
        acc_new       = dec_shift_add(accum_reg, b);

        case (mode_reg)
            MODE_TRACK:
            begin
                if (in_num_reg)
                begin
                    if (b == CHAR_SPACE)
                    begin
                        in_num_next = 1'b0;
                        cdone       = 1'b1;
                    end
                    else
                    begin
                        centroid_next = dec_shift_add(centroid_reg, b);
                    end
                end
                if (skip_reg)
                begin
                    skip_next   = 1'b0;
                    in_num_next = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (in_num_reg)
                begin
                    if (b == CHAR_SPACE)
                    begin
                        field_next = field_reg + 8'd1;
                        accum_next = 8'd0;
                    end
                    else if (b == CHAR_CR)
                    begin
                        field_next  = 8'd0;
                        accum_next  = 8'd0;
                        in_num_next = 1'b0;
                        mode_next   = MODE_IDLE;
                        tdone       = 1'b1;
                        for (int k = 0; k < NUM_COLOR / 2; k++)
                        begin
                            thr_next[2*k]   = params_reg[k] - params_reg[k + NUM_COLOR / 2];
                            thr_next[2*k+1] = params_reg[k] + params_reg[k + NUM_COLOR / 2];
                        end
                    end
                    else if (b >= DIGIT_0 && b <= DIGIT_9)
                    begin
                        accum_next = acc_new;
                        if (field_reg < 8'(NUM_COLOR))
                        begin
                            params_next[field_reg[2:0]] = acc_new;
                        end
                    end
                end
                if (skip_reg)
                begin
                    skip_next   = 1'b0;
                    in_num_next = 1'b1;
                end
            end
            default:
            begin
                // Idle: no mode action.
            end
        endcase

        // Command characters act after the mode action.
        if (b == CHAR_M)
        begin
            mode_next     = MODE_TRACK;
            skip_next     = 1'b1;
            centroid_next = 8'd0;
        end
        if (b == CHAR_S)
        begin
            mode_next  = MODE_IDENT;
            skip_next  = 1'b1;
            accum_next = 8'd0;
        end

        out_next.echo_byte       = b;
        out_next.centroid_x      = centroid_next;
        out_next.centroid_done   = cdone;
        out_next.prompt_seen     = (b == CHAR_COLON);
        out_next.red_low         = thr_next[0];
        out_next.red_high        = thr_next[1];
        out_next.green_low       = thr_next[2];
        out_next.green_high      = thr_next[3];
        out_next.blue_low        = thr_next[4];
        out_next.blue_high       = thr_next[5];
        out_next.thresholds_done = tdone;
    end

    // Control and parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            skip_reg      <= 1'b0;
            in_num_reg    <= 1'b0;
            field_reg     <= 8'd0;
            accum_reg     <= 8'd0;
            centroid_reg  <= 8'd0;
            for (int k = 0; k < NUM_COLOR; k++)
            begin
                params_reg[k] <= 8'd0;
                thr_reg[k]    <= 8'd0;
            end
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                mode_reg     <= mode_next;
                skip_reg     <= skip_next;
                in_num_reg   <= in_num_next;
                field_reg    <= field_next;
                accum_reg    <= accum_next;
                centroid_reg <= centroid_next;
                params_reg   <= params_next;
                thr_reg      <= thr_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg <= in_ch.payload.rx_byte;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    // A result cannot end a centroid and a threshold set at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.centroid_done && out_reg.thresholds_done))
        else $error("centroid_done and thresholds_done in one result");

    // A shown threshold result leaves the parser idle and out of number parsing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.thresholds_done) |-> (mode_reg == MODE_IDLE && !in_num_reg))
        else $error("parser not idle after thresholds_done");

    // Prompt pulse only on the colon character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.prompt_seen) |-> (out_reg.echo_byte == CHAR_COLON))
        else $error("prompt_seen without colon");

    // A stalled input stage keeps its request until the result stage frees up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("stalled input stage lost its request");

endmodule

// ===== test/camera_reply_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Camera reply parser checker
// Watches the request and result channels of the camera reply parser. Every
// accepted character runs through a cycle-free model of the parser, and the
// predicted result is queued. Every accepted result is compared field by
// field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module camera_reply_check
    import crp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic         req_ready,
    input  crp_request_t req,
    input  logic         res_valid,
    input  logic         res_ready,
    input  crp_result_t  res,
    output int           error_count,
    output int           pending
);

    // Model state of the parser.
    logic [1:0] cur_mode;
    logic       skip_pending;
    logic       digits_active;
    logic [7:0] field_no;
    logic [7:0] partial_value;
    logic [7:0] centroid;
    logic [7:0] color_param [NUM_COLOR];
    logic [7:0] threshold [NUM_COLOR];

    // Predicted results, oldest first.
    crp_result_t expected_replies [$];

    initial
    begin
        error_count = 0;
        pending = 0;
    end

    // Append one decimal digit to an 8-bit number, wrapping.
    function automatic logic [7:0] times_ten_plus(input logic [7:0] acc,
                                                  input logic [7:0] c);
        logic [7:0] sum;
        sum = acc * 8'd10 + c - DIGIT_0;
        return sum;
    endfunction

    // Advance the model by one character and build the expected result.
    function automatic crp_result_t parse_char(input logic [7:0] c);
        crp_result_t r;
        r = '0;
        case (cur_mode)
            MODE_TRACK:
            begin
                if (digits_active)
                begin
                    if (c == CHAR_SPACE)
                    begin
                        digits_active = 1'b0;
                        r.centroid_done = 1'b1;
                    end
                    else
                        centroid = times_ten_plus(centroid, c);
                end
                if (skip_pending)
                begin
                    skip_pending = 1'b0;
                    digits_active = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (digits_active)
                begin
                    if (c == CHAR_SPACE)
                    begin
                        field_no = field_no + 8'd1;
                        partial_value = '0;
                    end
                    else if (c == CHAR_CR)
                    begin
                        field_no = '0;
                        partial_value = '0;
                        digits_active = 1'b0;
                        cur_mode = MODE_IDLE;
                        r.thresholds_done = 1'b1;
                        for (int k = 0; k < 3; k++)
                        begin
                            threshold[2 * k]     = color_param[k] - color_param[k + 3];
                            threshold[2 * k + 1] = color_param[k] + color_param[k + 3];
                        end
                    end
                    else if (c >= DIGIT_0 && c <= DIGIT_9)
                    begin
                        partial_value = times_ten_plus(partial_value, c);
                        // Fields past the sixth still build a number but store nothing.
                        if (field_no < NUM_COLOR)
                            color_param[field_no[2:0]] = partial_value;
                    end
                end
                if (skip_pending)
                begin
                    skip_pending = 1'b0;
                    digits_active = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Character checks follow the mode action.
        if (c == CHAR_COLON)
            r.prompt_seen = 1'b1;
        if (c == CHAR_M)
        begin
            cur_mode = MODE_TRACK;
            skip_pending = 1'b1;
            centroid = '0;
        end
        if (c == CHAR_S)
        begin
            cur_mode = MODE_IDENT;
            skip_pending = 1'b1;
            partial_value = '0;
        end

        r.echo_byte  = c;
        r.centroid_x = centroid;
        r.red_low    = threshold[0];
        r.red_high   = threshold[1];
        r.green_low  = threshold[2];
        r.green_high = threshold[3];
        r.blue_low   = threshold[4];
        r.blue_high  = threshold[5];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Predict on every accepted character, compare on every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        crp_result_t want;
        if (!rst_n)
        begin
            cur_mode = MODE_IDLE;
            skip_pending = 1'b0;
            digits_active = 1'b0;
            field_no = '0;
            partial_value = '0;
            centroid = '0;
            for (int k = 0; k < NUM_COLOR; k++)
            begin
                color_param[k] = '0;
                threshold[k] = '0;
            end
            expected_replies.delete();
            pending <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_replies.push_back(parse_char(req.rx_byte));
            if (res_valid && res_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result with echo_byte %0d arrived with none expected",
                           res.echo_byte);
                    error_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    compare_field("echo_byte", want.echo_byte, res.echo_byte);
                    compare_field("centroid_x", want.centroid_x, res.centroid_x);
                    compare_field("centroid_done", 8'(want.centroid_done),
                                  8'(res.centroid_done));
                    compare_field("prompt_seen", 8'(want.prompt_seen),
                                  8'(res.prompt_seen));
                    compare_field("red_low", want.red_low, res.red_low);
                    compare_field("red_high", want.red_high, res.red_high);
                    compare_field("green_low", want.green_low, res.green_low);
                    compare_field("green_high", want.green_high, res.green_high);
                    compare_field("blue_low", want.blue_low, res.blue_low);
                    compare_field("blue_high", want.blue_high, res.blue_high);
                    compare_field("thresholds_done", 8'(want.thresholds_done),
                                  8'(res.thresholds_done));
                end
            end
            pending <= expected_replies.size();
        end
    end

endmodule

// ===== test/camera_reply_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Camera reply parser testbench
// Feeds the parser a short directed character sequence and then random
// camera replies: track and identify replies with random numbers, prompts
// and stray characters. Both channels idle at random, and once the result
// side holds off long enough for the parser to stall its input. A checker
// beside the parser predicts and compares every result.
// ----------------------------------------------------------------------------
module camera_reply_parser_test;
    import crp_pkg::*;

    localparam int CHAR_TARGET = 1800;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hold_off = 1'b0;
    int   chars_sent = 0;
    int   results_taken = 0;
    int   reply_errors;
    int   replies_pending;

    crp_stream_if #(.payload_t(crp_request_t)) in_ch ();
    crp_stream_if #(.payload_t(crp_result_t))  out_ch ();

    camera_reply_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    camera_reply_check reply_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (in_ch.valid),
        .req_ready   (in_ch.ready),
        .req         (in_ch.payload),
        .res_valid   (out_ch.valid),
        .res_ready   (out_ch.ready),
        .res         (out_ch.payload),
        .error_count (reply_errors),
        .pending     (replies_pending)
    );

    // Directed opening: extremes, track with wrap and a letter mid-number,
    // identify with empty fields, a field past the sixth and a prompt inside.
    logic [7:0] directed_chars [$] = '{
        CHAR_COLON, 8'h00, 8'hFF,
        CHAR_M, 8'h3F, DIGIT_9, DIGIT_9, 8'hFF, CHAR_M, DIGIT_0, DIGIT_0 + 8'd5, CHAR_SPACE,
        CHAR_S, 8'h78, DIGIT_0 + 8'd5, CHAR_SPACE, DIGIT_9, CHAR_SPACE, CHAR_SPACE,
        CHAR_SPACE, DIGIT_0 + 8'd7, CHAR_SPACE, CHAR_SPACE, DIGIT_0 + 8'd3, CHAR_COLON,
        CHAR_CR
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Send one character; called right after a rising edge, returns at the
    // edge where the request was accepted.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = (hold_off || chars_sent % 250 < 50) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.payload.rx_byte <= c;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    // Send a number in decimal without leading zeros.
    task automatic send_decimal(input int value);
        if (value >= 100)
            send_char(DIGIT_0 + 8'(value / 100));
        if (value >= 10)
            send_char(DIGIT_0 + 8'(value / 10 % 10));
        send_char(DIGIT_0 + 8'(value % 10));
    endtask

    // Track reply: 'M', a skipped character, up to three digits, usually a closing space.
    task automatic send_track_reply();
        int digits;
        send_char(CHAR_M);
        send_char(8'($urandom_range(0, 255)));
        digits = $urandom_range(0, 3);
        for (int i = 0; i < digits; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_char(8'($urandom_range(0, 255)));
            else
                send_char(DIGIT_0 + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) != 0)
            send_char(CHAR_SPACE);
    endtask

    // Identify reply: 'S', a skipped character, usually six numbers, usually a carriage return.
    task automatic send_ident_reply();
        int fields;
        send_char(CHAR_S);
        send_char(8'($urandom_range(0, 255)));
        fields = ($urandom_range(0, 7) != 0) ? NUM_COLOR : $urandom_range(0, 9);
        for (int i = 0; i < fields; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
                send_decimal($urandom_range(0, 999));
            else
                send_decimal($urandom_range(0, 255));
            if (i < fields - 1 || $urandom_range(0, 3) == 0)
                send_char(CHAR_SPACE);
            if ($urandom_range(0, 5) == 0)
                send_char(CHAR_SPACE);
        end
        if ($urandom_range(0, 9) != 0)
            send_char(CHAR_CR);
    endtask

    // Request side: reset, directed part, random replies, drain, verdict.
    initial
    begin
        int pick;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_chars[i])
            send_char(directed_chars[i]);

        while (chars_sent < CHAR_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_track_reply();
            else if (pick < 70)
                send_ident_reply();
            else if (pick < 80)
                send_char(CHAR_COLON);
            else if (pick < 85)
                send_char(CHAR_CR);
            else
                send_char(8'($urandom_range(0, 255)));
        end
        in_ch.valid <= 1'b0;

        // Let the last prediction land, then wait for every result.
        @(posedge clk);
        while (replies_pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (reply_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stall after each result, with calm stretches.
    initial
    begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                results_taken++;
                stall = (results_taken % 300 < 60) ? 0 : $urandom_range(0, 14);
            end
            else if (stall > 0)
                stall--;
            out_ch.ready <= (stall == 0) && !hold_off;
        end
    end

    // One long hold-off on the result side while requests keep coming.
    initial
    begin
        wait (chars_sent >= 700);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog.
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
